// File: rtl/put_pkg.sv
// ----------------------------------------------------------------------------
// put_pkg
// Shared types and codes of the pointer unification table.
// ----------------------------------------------------------------------------
package put_pkg;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_UNIFY      = 2'd2,
        CMD_DEUNIFY    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_RANGE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM_RD,
        ST_TRIM_CHK,
        ST_DEU_RD,
        ST_DEU_ADD,
        ST_FINISH
    } state_t;

    localparam int ADDR_WIDTH = 64;

endpackage

// File: rtl/put_ram.sv
// ----------------------------------------------------------------------------
// put_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module put_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/pointer_unification_table_unit.sv
// Register and unify scan the slots in use one by one; unregister scans the same way
// and then trims freed slots from the top of the table, reading and checking each in turn.
// Deunify checks the index range, reads one base and adds the offset. One item is worked
// on at a time: a new item is taken only after the result of the last one has moved into
// the output register. The single read port of the base memory sets the scan.
// Reset clears the control state at once; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
// pointer_unification_table_unit
// Table of allocation bases with register, unregister, unify and deunify.
// ----------------------------------------------------------------------------
module pointer_unification_table_unit #(
    parameter int TABLE_ENTRIES = 256,
    parameter int OFFSET_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address_value
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_value
    output logic [1:0]  m_tuser    // status
);

    import put_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = ADDR_WIDTH + 1;
    localparam logic [ADDR_WIDTH-1:0] OFS_MASK =
        {{(ADDR_WIDTH - OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [ADDR_WIDTH-1:0]   addr_reg, addr_next;
    logic [ADDR_WIDTH-1:0]   res_reg, res_next;
    status_t                 status_reg, status_next;
    logic [CNT_W-1:0]        slots_reg, slots_next;
    logic [CNT_W-1:0]        scan_ptr_reg, scan_ptr_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]        chk_idx_reg, chk_idx_next;
    logic                    rd_zero_reg, rd_zero_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [ADDR_WIDTH-1:0]   best_diff_reg, best_diff_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_WIDTH-1:0]   out_data_reg, out_data_next;
    status_t                 out_status_reg, out_status_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]        ram_rdata;

    logic [ADDR_WIDTH-1:0]   base_rd;
    logic                    free_rd;
    logic [ADDR_WIDTH:0]     diff_ext;
    logic                    base_le;
    logic                    reg_hit;
    logic                    unreg_hit;
    logic                    unify_better;
    logic                    scan_more;
    logic                    scan_done;
    logic [ADDR_WIDTH-1:0]   deu_index;
    logic                    deu_in_range;
    logic                    accept;
    logic                    out_load;

    put_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_base_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Slot 0 is never written; it always reads as a live entry with base zero.
    always_comb
    begin
        base_rd      = rd_zero_reg ? '0 : ram_rdata[ADDR_WIDTH-1:0];
        free_rd      = !rd_zero_reg && ram_rdata[ADDR_WIDTH];
        diff_ext     = {1'b0, addr_reg} - {1'b0, base_rd};
        base_le      = !diff_ext[ADDR_WIDTH];
        reg_hit      = chk_vld_reg && free_rd;
        unreg_hit    = chk_vld_reg && !free_rd && (base_rd == addr_reg);
        unify_better = chk_vld_reg && !free_rd && base_le
                       && (diff_ext[ADDR_WIDTH-1:0] < best_diff_reg);
        scan_more    = scan_ptr_reg < slots_reg;
        scan_done    = !chk_vld_reg && !scan_more;
        deu_index    = addr_reg >> OFFSET_BITS;
        deu_in_range = deu_index < ADDR_WIDTH'(slots_reg);
        accept       = s_tvalid && s_tready;
        out_load     = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd_t'(s_tuser) == CMD_DEUNIFY) ? ST_DEU_RD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (cmd_reg == CMD_REGISTER && reg_hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (cmd_reg == CMD_UNREGISTER && unreg_hit)
                begin
                    state_next = ST_TRIM_RD;
                end
            end
            ST_TRIM_RD:
            begin
                state_next = (slots_reg == CNT_ONE) ? ST_FINISH : ST_TRIM_CHK;
            end
            ST_TRIM_CHK:
            begin
                state_next = ram_rdata[ADDR_WIDTH] ? ST_TRIM_RD : ST_FINISH;
            end
            ST_DEU_RD:
            begin
                state_next = deu_in_range ? ST_DEU_ADD : ST_FINISH;
            end
            ST_DEU_ADD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        slots_next      = slots_reg;
        scan_ptr_next   = scan_ptr_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        best_next       = best_reg;
        best_diff_next  = best_diff_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = {1'b0, addr_reg};
        ram_re          = 1'b0;
        ram_raddr       = scan_ptr_reg[IDX_W-1:0];
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    cmd_next       = cmd_t'(s_tuser);
                    addr_next      = s_tdata;
                    res_next       = s_tdata;
                    status_next    = STATUS_OK;
                    scan_ptr_next  = CNT_ONE;
                    best_next      = '0;
                    best_diff_next = s_tdata;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    case (cmd_reg)
                        CMD_REGISTER:
                        begin
                            if (slots_reg == CNT_FULL)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slots_reg[IDX_W-1:0];
                                slots_next = slots_reg + CNT_ONE;
                            end
                        end
                        CMD_UNREGISTER:
                        begin
                            status_next = STATUS_MISSING;
                        end
                        default:
                        begin
                            res_next = (ADDR_WIDTH'(best_reg) << OFFSET_BITS) + best_diff_reg;
                        end
                    endcase
                end
                else if (cmd_reg == CMD_REGISTER && reg_hit)
                begin
                    ram_we = 1'b1;
                end
                else if (cmd_reg == CMD_UNREGISTER && unreg_hit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, addr_reg};
                end
                else
                begin
                    if (cmd_reg == CMD_UNIFY && unify_better)
                    begin
                        best_next      = chk_idx_reg;
                        best_diff_next = diff_ext[ADDR_WIDTH-1:0];
                    end
                    if (scan_more)
                    begin
                        ram_re        = 1'b1;
                        chk_vld_next  = 1'b1;
                        chk_idx_next  = scan_ptr_reg[IDX_W-1:0];
                        scan_ptr_next = scan_ptr_reg + CNT_ONE;
                    end
                end
            end
            ST_TRIM_RD:
            begin
                if (slots_reg != CNT_ONE)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(slots_reg - CNT_ONE);
                end
            end
            ST_TRIM_CHK:
            begin
                if (ram_rdata[ADDR_WIDTH])
                begin
                    slots_next = slots_reg - CNT_ONE;
                end
            end
            ST_DEU_RD:
            begin
                if (deu_in_range)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = deu_index[IDX_W-1:0];
                end
                else
                begin
                    res_next    = '0;
                    status_next = STATUS_RANGE;
                end
            end
            ST_DEU_ADD:
            begin
                res_next = base_rd + (addr_reg & OFS_MASK);
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rd_zero_next    = ram_re && (ram_raddr == '0);
        out_valid_next  = out_load || (out_valid_reg && !m_tready);
        out_data_next   = out_load ? res_reg : out_data_reg;
        out_status_next = out_load ? status_reg : out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slots_reg     <= CNT_ONE;
            chk_vld_reg   <= 1'b0;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slots_reg     <= slots_next;
            chk_vld_reg   <= chk_vld_next;
            rd_zero_reg   <= rd_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        scan_ptr_reg   <= scan_ptr_next;
        chk_idx_reg    <= chk_idx_next;
        best_reg       <= best_next;
        best_diff_reg  <= best_diff_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule
